### design/tbi_pkg.sv
`default_nettype none
package tbi_pkg;

   localparam int MaxTriangles = 256;
   localparam int CountWidth   = $clog2(MaxTriangles + 1);
   localparam int IndexWidth   = $clog2(MaxTriangles);

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] bx;
      logic signed [15:0] by_coord;
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic signed [31:0] a_value;
      logic signed [31:0] b_value;
      logic signed [31:0] c_value;
      logic signed [15:0] query_x;
      logic signed [15:0] query_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] interpolated_value;
      logic               contained;
      logic [7:0]         hit_triangle;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] x1;
      logic signed [15:0] y1;
      logic signed [15:0] x2;
      logic signed [15:0] y2;
      logic signed [15:0] x3;
      logic signed [15:0] y3;
   } tri_geom_type;

endpackage
`default_nettype wire

### design/triangle_barycentric_interpolator_core.sv
// Clear and load: accepted in idle, ready again the next cycle; no response.
// Query: each scanned triangle takes a row read, six products on one shared 17x17
// multiplier and an inside test. A hit adds three 35x32 weight products and a
// restoring divider before the response is valid. A miss over all N triangles
// gives the fill-value response, as does an empty table, which skips the scan.
// Synchronous active-high reset clears triangle count, fill value and control;
// the triangle table itself is not cleared.
`default_nettype none
module triangle_barycentric_interpolator_core (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  tbi_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output tbi_pkg::rsp_type     rsp_data,
   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wire  [31:0]          csr_data
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RD   = 4'd1;
   localparam logic [3:0] S_M0   = 4'd2;
   localparam logic [3:0] S_M1   = 4'd3;
   localparam logic [3:0] S_M2   = 4'd4;
   localparam logic [3:0] S_M3   = 4'd5;
   localparam logic [3:0] S_CHK  = 4'd6;
   localparam logic [3:0] S_W0   = 4'd7;
   localparam logic [3:0] S_W1   = 4'd8;
   localparam logic [3:0] S_W2   = 4'd9;
   localparam logic [3:0] S_DIV  = 4'd10;
   localparam logic [3:0] S_FIN  = 4'd11;
   localparam logic [3:0] S_OUT  = 4'd12;

   localparam int IW = tbi_pkg::IndexWidth;
   localparam int CW = tbi_pkg::CountWidth;

   tbi_pkg::tri_geom_type geom_mem [tbi_pkg::MaxTriangles];
   logic signed [95:0]    val_mem  [tbi_pkg::MaxTriangles];
   tbi_pkg::tri_geom_type geom_rd_ff;
   logic signed [95:0]    val_rd_ff;

   logic [3:0]         state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic signed [31:0] fill_ff;
   logic signed [15:0] px_ff, py_ff;
   logic signed [34:0] d_ff, d_in, n0_ff, n0_in, n1_ff, n1_in;
   logic signed [34:0] pa_ff, pa_in;
   logic signed [67:0] acc_ff, acc_in;
   logic [67:0]        rem_ff, rem_in;
   logic [67:0]        quo_ff, quo_in;
   logic [6:0]         step_ff, step_in;
   logic               neg_ff, neg_in;
   tbi_pkg::rsp_type   rsp_ff, rsp_in;

   logic signed [16:0] ma, mb;
   logic signed [33:0] mp;
   logic signed [34:0] wa;
   logic signed [31:0] wb;
   logic signed [66:0] wp;
   logic signed [34:0] n2;
   logic [34:0]        dabs;
   logic [68:0]        trial;
   logic               degenerate, hit;

   always_ff @(posedge clock) begin
      if (req_valid && req_ready && req_data.operation == tbi_pkg::OP_LOAD &&
          count_ff < CW'(tbi_pkg::MaxTriangles)) begin
         geom_mem[count_ff[IW-1:0]] <= '{req_data.ax, req_data.ay, req_data.bx,
            req_data.by_coord, req_data.cx, req_data.cy};
         val_mem[count_ff[IW-1:0]] <= {req_data.a_value, req_data.b_value,
            req_data.c_value};
      end
      geom_rd_ff <= geom_mem[idx_ff[IW-1:0]];
      val_rd_ff  <= val_mem[idx_ff[IW-1:0]];
   end

   // shared 17x17 multiplier for geometry terms
   always_comb begin
      unique case (state_ff)
         S_M0:    begin ma = 17'(geom_rd_ff.y2) - 17'(geom_rd_ff.y3);
                        mb = 17'(geom_rd_ff.x1) - 17'(geom_rd_ff.x3); end
         S_M1:    begin ma = 17'(geom_rd_ff.x3) - 17'(geom_rd_ff.x2);
                        mb = 17'(geom_rd_ff.y1) - 17'(geom_rd_ff.y3); end
         S_M2:    begin ma = 17'(geom_rd_ff.y2) - 17'(geom_rd_ff.y3);
                        mb = 17'(px_ff) - 17'(geom_rd_ff.x3); end
         S_M3:    begin ma = 17'(geom_rd_ff.x3) - 17'(geom_rd_ff.x2);
                        mb = 17'(py_ff) - 17'(geom_rd_ff.y3); end
         S_CHK:   begin ma = 17'(geom_rd_ff.y3) - 17'(geom_rd_ff.y1);
                        mb = 17'(px_ff) - 17'(geom_rd_ff.x3); end
         S_W0:    begin ma = 17'(geom_rd_ff.x1) - 17'(geom_rd_ff.x3);
                        mb = 17'(py_ff) - 17'(geom_rd_ff.y3); end
         default: begin ma = '0; mb = '0; end
      endcase
   end
   assign mp = ma * mb;

   assign n2   = d_ff - n0_ff - n1_ff;
   assign dabs = d_ff[34] ? 35'(-d_ff) : 35'(d_ff);

   always_comb begin
      unique case (state_ff)
         S_W1:    begin wa = n1_ff; wb = val_rd_ff[63:32]; end
         S_W2:    begin wa = n2;    wb = val_rd_ff[31:0];  end
         default: begin wa = n0_ff; wb = val_rd_ff[95:64]; end
      endcase
   end
   assign wp = 67'(wa) * 67'(wb);

   assign trial = {rem_ff, quo_ff[67]} - {34'd0, dabs};

   always_comb begin
      degenerate = (d_ff == '0);
      hit = !degenerate &&
            (d_ff[34] ? (n0_ff < 0 && n1_ff < 0 && n2 < 0)
                      : (n0_ff > 0 && n1_ff > 0 && n2 > 0));
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      d_in     = d_ff;
      n0_in    = n0_ff;
      n1_in    = n1_ff;
      pa_in    = pa_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      neg_in   = neg_ff;
      rsp_in   = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_data.operation)
                  tbi_pkg::OP_CLEAR: count_in = '0;
                  tbi_pkg::OP_LOAD:
                     if (count_ff < CW'(tbi_pkg::MaxTriangles))
                        count_in = count_ff + 1'b1;
                  tbi_pkg::OP_QUERY: begin
                     idx_in = '0;
                     if (count_ff == '0) begin
                        rsp_in   = '{fill_ff, 1'b0, 8'd0};
                        state_in = S_OUT;
                     end else begin
                        state_in = S_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_RD: state_in = S_M0;
         S_M0: begin pa_in = 35'(mp); state_in = S_M1; end
         S_M1: begin d_in = pa_ff + 35'(mp); state_in = S_M2; end
         S_M2: begin pa_in = 35'(mp); state_in = S_M3; end
         S_M3: begin n0_in = pa_ff + 35'(mp); state_in = S_CHK; end
         S_CHK: begin
            pa_in = 35'(mp);
            state_in = S_W0;
         end
         S_W0: begin
            n1_in    = pa_ff + 35'(mp);
            state_in = S_FIN;
         end
         S_FIN: begin
            if (hit) begin
               neg_in   = d_ff[34];
               acc_in   = 68'(wp);
               state_in = S_W1;
            end else if (idx_ff + 1'b1 == count_ff) begin
               rsp_in   = '{fill_ff, 1'b0, 8'd0};
               state_in = S_OUT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_W1: begin acc_in = acc_ff + 68'(wp); state_in = S_W2; end
         S_W2: begin
            acc_in = acc_ff + 68'(wp);
            if (neg_ff) acc_in = -(acc_ff + 68'(wp));
            rem_in   = '0;
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (step_ff == 7'd0) begin
               neg_in = acc_ff[67];
               quo_in = acc_ff[67] ? 68'(-acc_ff) : acc_ff;
               step_in = 7'd1;
            end else if (step_ff <= 7'd68) begin
               if (!trial[68]) rem_in = trial[67:0];
               else            rem_in = {rem_ff[66:0], quo_ff[67]};
               quo_in  = {quo_ff[66:0], !trial[68]};
               step_in = step_ff + 1'b1;
            end else begin
               rsp_in = '{neg_ff ? 32'(-quo_ff) : quo_ff[31:0], 1'b1,
                          idx_ff[7:0]};
               state_in = S_OUT;
            end
         end
         S_OUT: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_valid && csr_ready) fill_ff <= csr_data;
      end
      idx_ff  <= idx_in;
      d_ff    <= d_in;
      n0_ff   <= n0_in;
      n1_ff   <= n1_in;
      pa_ff   <= pa_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      neg_ff  <= neg_in;
      rsp_ff  <= rsp_in;
      if (req_valid && req_ready) begin
         px_ff <= req_data.query_x;
         py_ff <= req_data.query_y;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data  = rsp_ff;

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(tbi_pkg::MaxTriangles)) else $error("count overflow");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.contained |-> rsp_data.hit_triangle == 8'd0)
      else $error("miss with index");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped");
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIN |-> idx_ff < count_ff) else $error("scan past count");

endmodule
`default_nettype wire
